// ===== hw/rtl/cpom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpom_pkg
// Shared constants and types for the causal pair offset matcher.
// ----------------------------------------------------------------------------
package cpom_pkg;

	localparam int TableEntries = 256;
	localparam int NodeCount    = 16;
	localparam int KeyBits      = 64;
	localparam int StampW       = 62;
	localparam int OffsetW      = 63;

	typedef enum logic [1:0] {
		FUNC_EVENT = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic search;
		logic remove;
		logic insert;
		logic clear;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/cpom_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpom_cell
// One table entry: key compare, hit/free chain, insert, remove and clear.
// ----------------------------------------------------------------------------
module cpom_cell #(
	parameter int KEY_BITS = cpom_pkg::KeyBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cpom_pkg::cell_cmd_t         cmd,
	input  logic [KEY_BITS-1:0]         key,
	input  logic [cpom_pkg::StampW-1:0] stamp,
	input  logic                        hit_in,
	input  logic                        free_in,
	output logic                        hit_out,
	output logic                        free_out,
	output logic                        hit_here,
	output logic [cpom_pkg::StampW-1:0] stamp_out
);

	logic                        valid_q;
	logic                        hitflag_q;
	logic                        freeflag_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [cpom_pkg::StampW-1:0] stamp_q;
	logic                        eq;

	assign eq        = valid_q && (key_q == key);
	// first-hit and first-free priority chains
	assign hit_out   = hit_in | eq;
	assign free_out  = free_in | !valid_q;
	assign hit_here  = hitflag_q;
	assign stamp_out = stamp_q;

	// clear, or latch search results, then apply remove or insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			hitflag_q  <= 1'b0;
			freeflag_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q    <= 1'b0;
			hitflag_q  <= 1'b0;
			freeflag_q <= 1'b0;
		end else if (cmd.search) begin
			hitflag_q  <= eq && !hit_in;
			freeflag_q <= !valid_q && !free_in;
		end else begin
			if (cmd.remove && hitflag_q)
				valid_q <= 1'b0;
			if (cmd.insert && freeflag_q)
				valid_q <= 1'b1;
		end
	end

	// store payload on insert
	always_ff @(posedge clk) begin
		if (cmd.insert && freeflag_q && !cmd.search) begin
			key_q   <= key;
			stamp_q <= stamp;
		end
	end

endmodule

// ===== hw/rtl/causal_pair_offset_matcher_unit.sv =====
`timescale 1ns / 1ps
// Sequence: an event is searched in the accept cycle and the cells and offsets
// are updated in the next; the result is registered and valid after the update.
// Each item runs search, update and result handshake; the input stalls until
// the result leaves, so a new item is taken only once the last result is accepted.
// Reset: arst_n clears every occupancy bit and node offset at once.
// ----------------------------------------------------------------------------
// causal_pair_offset_matcher_unit
// Key table as a row of cells plus per-node offset registers.
// ----------------------------------------------------------------------------
module causal_pair_offset_matcher_unit #(
	parameter int TABLE_ENTRIES = cpom_pkg::TableEntries,
	parameter int NODE_COUNT    = cpom_pkg::NodeCount,
	parameter int KEY_BITS      = cpom_pkg::KeyBits
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         func,
	input  logic [63:0]                        match_key,
	input  logic                               is_dependent,
	input  logic                               from_main_node,
	input  logic [3:0]                         node_index,
	input  logic [cpom_pkg::StampW-1:0]        stamp,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               matched,
	output logic                               dropped,
	output logic signed [cpom_pkg::OffsetW-1:0] offset_value
);

	localparam int SW = cpom_pkg::StampW;
	localparam int OW = cpom_pkg::OffsetW;

	typedef enum logic [1:0] {IDLE, UPDATE, DONE} state_t;

	state_t                  state_q;
	cpom_pkg::func_t         func_q;
	logic [KEY_BITS-1:0]     key_q;
	logic                    dep_q, main_q;
	logic [3:0]              node_q;
	logic [SW-1:0]           stamp_q;
	logic                    any_hit_q, any_free_q;
	logic signed [OW-1:0]    offs_q [NODE_COUNT];

	cpom_pkg::cell_cmd_t     cmd;
	logic [TABLE_ENTRIES:0]  hit_ch, free_ch;
	logic [TABLE_ENTRIES-1:0] hit_here;
	logic [SW-1:0]           cell_stamp [TABLE_ENTRIES];
	logic [SW-1:0]           hit_stamp;
	logic                    node_ok;
	logic signed [OW:0]      diff;
	logic signed [OW-1:0]    dsat, cur;

	assign in_stall = (state_q != IDLE);
	assign hit_ch[0]  = 1'b0;
	assign free_ch[0] = 1'b0;
	assign node_ok = (32'(node_q) < NODE_COUNT);

	// command to cells: search in the accept cycle, update the next
	always_comb begin
		cmd = '0;
		cmd.search = (state_q == IDLE) && in_valid && (func == cpom_pkg::FUNC_EVENT);
		cmd.clear  = (state_q == UPDATE) && (func_q == cpom_pkg::FUNC_CLEAR);
		cmd.remove = (state_q == UPDATE) && (func_q == cpom_pkg::FUNC_EVENT) && any_hit_q;
		cmd.insert = (state_q == UPDATE) && (func_q == cpom_pkg::FUNC_EVENT) && !any_hit_q;
	end

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			cpom_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd),
				.key(cmd.search ? match_key[KEY_BITS-1:0] : key_q),
				.stamp(stamp_q),
				.hit_in(hit_ch[g]), .free_in(free_ch[g]),
				.hit_out(hit_ch[g+1]), .free_out(free_ch[g+1]),
				.hit_here(hit_here[g]), .stamp_out(cell_stamp[g])
			);
		end
	endgenerate

	// one-hot select of the hit entry stamp
	always_comb begin
		hit_stamp = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			hit_stamp = hit_stamp | (cell_stamp[i] & {SW{hit_here[i]}});
	end

	// offset candidate, saturated
	always_comb begin
		diff = $signed({2'b00, hit_stamp}) - $signed({2'b00, stamp_q}) - 64'sd1;
		if (diff < -($signed({2'b01, {(OW-1){1'b0}}})))
			dsat = {1'b1, {(OW-1){1'b0}}};
		else
			dsat = diff[OW-1:0];
		cur = node_ok ? offs_q[node_q] : '0;
	end

	// sequence the item and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			out_valid    <= 1'b0;
			func_q       <= cpom_pkg::FUNC_EVENT;
			key_q        <= '0;
			dep_q        <= 1'b0;
			main_q       <= 1'b0;
			node_q       <= '0;
			stamp_q      <= '0;
			any_hit_q    <= 1'b0;
			any_free_q   <= 1'b0;
			matched      <= 1'b0;
			dropped      <= 1'b0;
			offset_value <= '0;
			for (int i = 0; i < NODE_COUNT; i++) offs_q[i] <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						func_q     <= cpom_pkg::func_t'(func);
						key_q      <= match_key[KEY_BITS-1:0];
						dep_q      <= is_dependent;
						main_q     <= from_main_node;
						node_q     <= node_index;
						stamp_q    <= stamp;
						any_hit_q  <= hit_ch[TABLE_ENTRIES];
						any_free_q <= free_ch[TABLE_ENTRIES];
						state_q    <= UPDATE;
					end
				end
				UPDATE: begin
					matched      <= 1'b0;
					dropped      <= 1'b0;
					offset_value <= '0;
					case (func_q)
						cpom_pkg::FUNC_EVENT: begin
							matched      <= any_hit_q;
							dropped      <= !any_hit_q && !any_free_q;
							offset_value <= cur;
							if (any_hit_q && !dep_q && main_q && node_ok && dsat < cur) begin
								offs_q[node_q] <= dsat;
								offset_value   <= dsat;
							end
						end
						cpom_pkg::FUNC_READ: offset_value <= cur;
						cpom_pkg::FUNC_CLEAR:
							for (int i = 0; i < NODE_COUNT; i++) offs_q[i] <= '0;
						default: ;
					endcase
					out_valid <= 1'b1;
					state_q   <= DONE;
				end
				DONE: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cpom_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpom_assert_checker
// Port-level checks for the causal pair offset matcher.
// ----------------------------------------------------------------------------
module cpom_assert_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic                matched,
	input logic                dropped,
	input logic signed [62:0]  offset_value
);

	// a result never reports both a match and a drop
	ast_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && dropped)) else $error("matched and dropped");

	// offsets never rise above zero
	ast_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (offset_value[62] || offset_value == '0)) else $error("positive offset");

	// no new item while a result is pending
	ast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while busy");

	// stalled result holds
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(offset_value)) else $error("result lost");

endmodule

bind causal_pair_offset_matcher_unit cpom_assert_checker u_cpom_checker (.*);
